/* src/wid_pkg.sv */
// ----------------------------------------------------------------------------
// wid_pkg
// Shared constants for the weighted index draw block: field widths, opcodes,
// register map and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package wid_pkg;

  // Item field widths
  localparam int OPCODE_W  = 1;
  localparam int INDEX_W   = 6;
  localparam int WEIGHT_W  = 16;
  localparam int UNIFORM_W = 16;

  // Configuration register
  localparam int          CFG_W             = 7;
  localparam logic [6:0]  CFG_ENTRIES_RESET = 7'd64;
  localparam int          APB_ADDR_W        = 3;
  localparam int          APB_DATA_W        = 32;
  localparam logic        REG_ENTRIES       = 1'b0;   // word index of entries_in_use

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 1'b1;

  // Parameter defaults
  localparam int ENTRIES_DEF      = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int UNIFORM_BITS_DEF = 16;

  // Multiplier digit for scaling the total by the uniform fraction
  localparam int DIGIT_W = 8;

endpackage

`default_nettype wire

/* src/wid_in_if.sv */
// ----------------------------------------------------------------------------
// wid_in_if
// Input channel: weight write or draw request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wid_in_if;
  logic                           valid;
  logic                           ready;
  logic [wid_pkg::OPCODE_W-1:0]   opcode;
  logic [wid_pkg::INDEX_W-1:0]    entry_index;
  logic [wid_pkg::WEIGHT_W-1:0]   weight_value;
  logic [wid_pkg::UNIFORM_W-1:0]  uniform_draw;

  modport source (output valid, output opcode, output entry_index,
                  output weight_value, output uniform_draw, input ready);
  modport sink   (input valid, input opcode, input entry_index,
                  input weight_value, input uniform_draw, output ready);
endinterface

`default_nettype wire

/* src/wid_out_if.sv */
// ----------------------------------------------------------------------------
// wid_out_if
// Output channel: drawn index and fall-through flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wid_out_if;
  logic                         valid;
  logic                         ready;
  logic [wid_pkg::INDEX_W-1:0]  picked_index;
  logic                         fell_through;

  modport source (output valid, output picked_index, output fell_through,
                  input ready);
  modport sink   (input valid, input picked_index, input fell_through,
                  output ready);
endinterface

`default_nettype wire

/* src/weighted_index_draw.sv */
// ----------------------------------------------------------------------------
// weighted_index_draw
// Roulette-wheel selection over a table of integer weights kept in one
// synchronous memory, with the running total held beside it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake. opcode OP_WRITE replaces the weight
//   of entry_index and adjusts the total; it gives no result. opcode OP_DRAW
//   scales the total by uniform_draw / 2^UNIFORM_BITS and returns on out_ch
//   the first index whose running sum exceeds that target, or index 0 with
//   fell_through set when none of the walked entries does.
//   The APB port holds entries_in_use (byte address 0), the walk length.
//   One item is worked at a time. A write reads the old weight, then writes
//   the new one and adjusts the total. A draw first multiplies the total by
//   the uniform fraction one 8-bit digit at a time (2 digits by default),
//   then walks the entries from index 0 until one hits or entries_in_use
//   (capped at ENTRIES) are read; a zero walk length goes straight to the
//   result. The walk reads one weight per cycle from the single memory read
//   port; the next item is taken in the cycle after the result.
//   After reset the block clears the weight memory, one entry per cycle,
//   before it accepts an item; APB writes are taken meanwhile.
//   The result waits in an output register while out_ch stalls; the next
//   item is accepted, and only its result is held back until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_index_draw #(
  parameter int ENTRIES      = wid_pkg::ENTRIES_DEF,
  parameter int WEIGHT_BITS  = wid_pkg::WEIGHT_BITS_DEF,
  parameter int UNIFORM_BITS = wid_pkg::UNIFORM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  wid_in_if.sink                              in_ch,
  wid_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wid_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wid_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wid_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int TOT_BITS = WEIGHT_BITS + IDX_BITS;
  localparam int UW       = (UNIFORM_BITS < wid_pkg::UNIFORM_W) ? UNIFORM_BITS
                                                                : wid_pkg::UNIFORM_W;
  localparam int DW       = wid_pkg::DIGIT_W;
  localparam int NDIG     = (UW + DW - 1) / DW;
  localparam int UWP      = NDIG * DW;
  localparam int PW       = TOT_BITS + UNIFORM_BITS;
  localparam int DCW      = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNTW0    = $clog2(ENTRIES + 1);
  localparam int CW       = (CNTW0 > wid_pkg::CFG_W) ? CNTW0 : wid_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WUPD, S_MUL, S_WALK, S_EMIT
  } state_t;

  state_t                      state;
  logic [IDX_BITS-1:0]         ptr;
  logic                        issue_done;
  logic                        rd_vld;
  logic [IDX_BITS-1:0]         rd_idx;
  logic [DCW-1:0]              dig_cnt;
  logic [wid_pkg::CFG_W-1:0]   entries_in_use;
  logic [TOT_BITS-1:0]         total;
  logic                        out_valid;
  logic [wid_pkg::INDEX_W-1:0] out_index;
  logic                        out_fall;

  // datapath registers
  logic [PW-1:0]               acc;
  logic [UWP-1:0]              u_sh;
  logic [TOT_BITS-1:0]         cum;
  logic [IDX_BITS-1:0]         wr_idx;
  logic [WEIGHT_BITS-1:0]      wr_val;
  logic                        wr_ok;
  logic [IDX_BITS-1:0]         res_idx;
  logic                        res_fall;

  // memory
  logic [WEIGHT_BITS-1:0]      mem [ENTRIES];
  logic [WEIGHT_BITS-1:0]      rd_data;
  logic                        mem_we;
  logic [IDX_BITS-1:0]         mem_waddr;
  logic [WEIGHT_BITS-1:0]      mem_wdata;
  logic [IDX_BITS-1:0]         mem_raddr;

  logic                        in_fire;
  logic                        out_free;
  logic                        cfg_wr;
  logic [IDX_BITS-1:0]         in_idx;
  logic                        in_idx_ok;
  logic [CW-1:0]               lim;
  logic                        lim_zero;
  logic [IDX_BITS-1:0]         walk_last;
  logic [TOT_BITS-1:0]         target;
  logic [TOT_BITS-1:0]         rd_sum;
  logic                        walk_now;
  logic                        hit;
  logic                        walk_end;
  logic [TOT_BITS+DW-1:0]      pp;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;
  assign cfg_wr    = psel && penable && pwrite && pready
                     && (paddr[2] == wid_pkg::REG_ENTRIES);
  assign in_idx    = IDX_BITS'(in_ch.entry_index);
  assign in_idx_ok = 32'(in_ch.entry_index) < 32'(ENTRIES);

  // walk length, capped at the table size
  assign lim       = (CW'(entries_in_use) > CW'(ENTRIES)) ? CW'(ENTRIES)
                                                          : CW'(entries_in_use);
  assign lim_zero  = (lim == '0);
  assign walk_last = IDX_BITS'(lim - CW'(1));

  assign target    = acc[PW-1:UNIFORM_BITS];
  assign rd_sum    = cum + TOT_BITS'(rd_data);
  assign walk_now  = (state == S_WALK) && rd_vld;
  assign hit       = walk_now && (rd_sum > target);
  assign walk_end  = walk_now && !hit && (rd_idx == walk_last);
  assign pp        = (TOT_BITS+DW)'(total) * (TOT_BITS+DW)'(u_sh[UWP-1 -: DW]);

  assign mem_we    = (state == S_CLEAR) || ((state == S_WUPD) && wr_ok);
  assign mem_waddr = (state == S_CLEAR) ? ptr : wr_idx;
  assign mem_wdata = (state == S_CLEAR) ? '0 : wr_val;
  assign mem_raddr = (state == S_WALK) ? ptr : in_idx;

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.picked_index = out_index;
  assign out_ch.fell_through = out_fall;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wid_pkg::REG_ENTRIES)
                  ? wid_pkg::APB_DATA_W'(entries_in_use) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      ptr            <= '0;
      issue_done     <= 1'b1;
      rd_vld         <= 1'b0;
      dig_cnt        <= '0;
      entries_in_use <= wid_pkg::CFG_ENTRIES_RESET;
      total          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        entries_in_use <= pwdata[wid_pkg::CFG_W-1:0];
      end
      // raise on a new result, drop once the receiver takes the item
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= (state == S_WALK) && !issue_done;

      unique case (state)
        S_CLEAR: begin
          if (ptr == IDX_BITS'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + IDX_BITS'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            dig_cnt <= '0;
            state   <= (in_ch.opcode == wid_pkg::OP_DRAW) ? S_MUL : S_WUPD;
          end
        end
        S_WUPD: begin
          if (wr_ok) begin
            total <= total - TOT_BITS'(rd_data) + TOT_BITS'(wr_val);
          end
          state <= S_IDLE;
        end
        S_MUL: begin
          dig_cnt <= dig_cnt + DCW'(1);
          if (dig_cnt == DCW'(NDIG - 1)) begin
            ptr        <= '0;
            issue_done <= 1'b0;
            state      <= lim_zero ? S_EMIT : S_WALK;
          end
        end
        S_WALK: begin
          if (hit || walk_end) begin
            issue_done <= 1'b1;
            state      <= S_EMIT;
          end else if (!issue_done) begin
            // issue one read per cycle until the last walked entry
            if (ptr == walk_last) begin
              issue_done <= 1'b1;
            end else begin
              ptr <= ptr + IDX_BITS'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_index <= wid_pkg::INDEX_W'(res_idx);
            out_fall  <= res_fall;
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_idx <= ptr;
    if (in_fire) begin
      wr_idx <= in_idx;
      wr_val <= WEIGHT_BITS'(in_ch.weight_value);
      wr_ok  <= in_idx_ok;
      acc    <= '0;
      u_sh   <= UWP'(in_ch.uniform_draw[UW-1:0]);
    end
    if (state == S_MUL) begin
      acc  <= (acc << DW) + PW'(pp);
      u_sh <= u_sh << DW;
      cum  <= '0;
      // a zero-length walk falls through
      res_idx  <= '0;
      res_fall <= 1'b1;
    end
    if (walk_now) begin
      cum <= rd_sum;
      if (hit) begin
        res_idx  <= rd_idx;
        res_fall <= 1'b0;
      end else begin
        res_idx  <= '0;
        res_fall <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fall_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.fell_through |-> out_ch.picked_index == '0)
    else $error("fall-through result with nonzero index");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_WUPD |=> $stable(total))
    else $error("weight total changed outside a write update");

  a_cum_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> cum <= total)
    else $error("running sum exceeds weight total");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    walk_now |-> rd_idx <= walk_last)
    else $error("walk read beyond the walk length");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives weight writes and draws into weighted_index_draw under random gaps
// and stalls, predicts every picked index from a local copy of the weight
// table, running total and walk length, and compares each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wid_pkg::APB_ADDR_W-1:0] ENTRIES_ADDR = {wid_pkg::REG_ENTRIES, 2'b00};
  localparam int                   TABLE_SIZE   = wid_pkg::ENTRIES_DEF;

  typedef struct packed {
    logic [wid_pkg::INDEX_W-1:0] idx;
    logic                        fell;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [wid_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [wid_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [wid_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  wid_in_if  in_ch ();
  wid_out_if out_ch ();

  weighted_index_draw uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the block's state
  logic [wid_pkg::WEIGHT_W-1:0] weight_table [TABLE_SIZE];
  logic [21:0]                  weight_sum;
  logic [wid_pkg::CFG_W-1:0]    walk_len;

  pick_t pending_picks [$];
  int    errors      = 0;
  bit    quiet       = 1'b0;
  int    hold_cycles = 0;
  int    stall_left  = 0;

  always #10 clk = ~clk;

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.opcode       = wid_pkg::OP_WRITE;
    in_ch.entry_index  = '0;
    in_ch.weight_value = '0;
    in_ch.uniform_draw = '0;
  end

  function automatic pick_t draw_pick(input logic [wid_pkg::UNIFORM_W-1:0] u);
    logic [37:0] scaled;
    logic [21:0] target;
    logic [22:0] run_sum;
    int          limit;
    pick_t       res;
    scaled  = weight_sum * u;
    target  = scaled[37:16];
    limit   = (walk_len > TABLE_SIZE) ? TABLE_SIZE : int'(walk_len);
    run_sum = '0;
    res.idx  = '0;
    res.fell = 1'b1;
    for (int i = 0; i < limit; i++) begin
      run_sum = run_sum + weight_table[i];
      if (target < run_sum) begin
        res.idx  = wid_pkg::INDEX_W'(i);
        res.fell = 1'b0;
        return res;
      end
    end
    return res;
  endfunction

  function automatic logic [wid_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return wid_pkg::WEIGHT_W'($urandom_range(0, 15));
      2: return '1;
      default: return wid_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [wid_pkg::UNIFORM_W-1:0] rand_uniform();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return wid_pkg::UNIFORM_W'($urandom);
    endcase
  endfunction

  // One item on in_ch; predict its effect once it is accepted.
  task automatic send_item(input logic [wid_pkg::OPCODE_W-1:0] op,
                           input logic [wid_pkg::INDEX_W-1:0] idx,
                           input logic [wid_pkg::WEIGHT_W-1:0] w,
                           input logic [wid_pkg::UNIFORM_W-1:0] u);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.entry_index  <= idx;
    in_ch.weight_value <= w;
    in_ch.uniform_draw <= u;
    do @(posedge clk); while (!in_ch.ready);
    if (op == wid_pkg::OP_WRITE) begin
      weight_sum        = weight_sum - weight_table[idx] + w;
      weight_table[idx] = w;
    end else begin
      pending_picks.push_back(draw_pick(u));
    end
  endtask

  task automatic write_weight(input int idx, input logic [wid_pkg::WEIGHT_W-1:0] w);
    send_item(wid_pkg::OP_WRITE, wid_pkg::INDEX_W'(idx), w, wid_pkg::UNIFORM_W'($urandom));
  endtask

  task automatic draw(input logic [wid_pkg::UNIFORM_W-1:0] u);
    send_item(wid_pkg::OP_DRAW, wid_pkg::INDEX_W'($urandom),
              wid_pkg::WEIGHT_W'($urandom), u);
  endtask

  // Drop valid, wait for every pick, then let the clock idle before returning.
  task automatic drain_draws();
    int waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_picks.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_picks.size() != 0) begin
      $error("%0d picks never arrived", pending_picks.size());
      errors++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic set_walk_len(input logic [wid_pkg::CFG_W-1:0] n);
    logic [wid_pkg::APB_DATA_W-1:0] data;
    data = $urandom;
    data[wid_pkg::CFG_W-1:0] = n;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRIES_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    walk_len = n;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected pick: picked_index %0d fell_through %0b",
               out_ch.picked_index, out_ch.fell_through);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        if (out_ch.picked_index !== want.idx) begin
          $error("picked_index: expected %0d, got %0d", want.idx, out_ch.picked_index);
          errors++;
        end
        if (out_ch.fell_through !== want.fell) begin
          $error("fell_through: expected %0b, got %0b", want.fell, out_ch.fell_through);
          errors++;
        end
      end
    end
  end

  task automatic test_table_extremes();
    draw('0);
    draw('1);
    write_weight(0, '1);
    write_weight(TABLE_SIZE - 1, '1);
    draw('0);
    draw(16'h8000);
    draw(16'h7FFF);
    draw('1);
    write_weight(TABLE_SIZE - 1, '0);
    draw('1);
    write_weight(21, 16'h2A2A);
    write_weight(42, 16'h5555);
    draw(16'h5555);
    draw(16'hAAAA);
    write_weight(0, '0);
    draw(16'h0001);
    draw('1);
    drain_draws();
  endtask

  task automatic test_walk_lengths();
    set_walk_len(7'd32);      // weight beyond the walk forces fall-through
    draw('1);
    draw(16'h0100);
    drain_draws();
    set_walk_len(7'd0);
    draw(16'h1234);
    drain_draws();
    set_walk_len(7'd127);
    draw('1);
    drain_draws();
    set_walk_len(7'd1);
    write_weight(0, 16'h0010);
    draw('0);
    draw('1);
    drain_draws();
    set_walk_len(7'd64);
  endtask

  task automatic test_random_mix(input int n_items, input logic [wid_pkg::CFG_W-1:0] len);
    int span;
    drain_draws();
    set_walk_len(len);
    span = (len == 0 || len > TABLE_SIZE) ? TABLE_SIZE : int'(len);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 1) == 0) write_weight($urandom_range(0, span - 1), rand_weight());
        else write_weight($urandom_range(0, TABLE_SIZE - 1), rand_weight());
      end else begin
        draw(rand_uniform());
      end
    end
    drain_draws();
  endtask

  // Hold the receiver off long enough that the block fills and stalls in_ch.
  task automatic test_output_hold();
    hold_cycles = 400;
    for (int k = 0; k < 12; k++) draw(rand_uniform());
    drain_draws();
  endtask

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) weight_table[i] = '0;
    weight_sum = '0;
    walk_len   = wid_pkg::CFG_ENTRIES_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_extremes();
    test_walk_lengths();
    test_random_mix(260, 7'd64);
    test_random_mix(200, 7'd1);
    test_random_mix(200, 7'($urandom_range(2, 63)));
    test_random_mix(60, 7'd0);
    test_random_mix(200, 7'd127);
    test_random_mix(200, 7'd65);
    test_output_hold();
    test_random_mix(120, 7'($urandom_range(2, 63)));
    quiet = 1'b1;
    test_random_mix(150, 7'd64);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
